### design/lmrr_pkg.sv
// Shared types and constants for the lock manager with revoke and retry.
package lmrr_pkg;

	localparam int NUM_LOCKS   = 256;
	localparam int NUM_CLIENTS = 16;
	localparam int SLOT_W      = $clog2(NUM_LOCKS);
	localparam int CLIENT_W    = $clog2(NUM_CLIENTS);
	localparam int LOCK_W      = 8;
	localparam int ID_W        = 4;
	localparam int KIND_W      = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_GRANT        = 3'd0,
		KIND_RETRY_REPLY  = 3'd1,
		KIND_REVOKE       = 3'd2,
		KIND_RETRY_WAITER = 3'd3,
		KIND_ACK          = 3'd4,
		KIND_ERROR        = 3'd5
	} msg_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_REVOKE,
		ST_WALK
	} ctrl_state_t;

	typedef struct packed {
		logic                   held;
		logic [CLIENT_W-1:0]    owner;
		logic [NUM_CLIENTS-1:0] waiters;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		entry_t            data;
	} tbl_wr_t;

	typedef struct packed {
		msg_kind_t   kind;
		logic [ID_W-1:0]   target;
		logic [LOCK_W-1:0] lock;
		logic              last;
	} msg_t;

endpackage

### design/lmrr_table.sv
// Lock table memory: one entry per lock, registered read, valid bits for reset.
module lmrr_table (
	input  logic            clk,
	input  logic            arst_n,
	input  lmrr_pkg::tbl_rd_t rd,
	input  lmrr_pkg::tbl_wr_t wr,
	output lmrr_pkg::entry_t  rd_data
);
	import lmrr_pkg::*;

	entry_t                 mem [NUM_LOCKS];
	logic [NUM_LOCKS-1:0]   valid_q;
	entry_t                 mem_data_s1;
	logic                   vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			mem_data_s1 <= mem[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				vld_s1 <= valid_q[rd.addr];
			end
		end
	end

	// never-written entries read as a free lock
	assign rd_data = vld_s1 ? mem_data_s1 : '0;

endmodule

### design/lmrr_ctrl.sv
// Request sequencer: read-modify-write of the lock entry and message emission.
module lmrr_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic                       req_type,
	input  logic [lmrr_pkg::LOCK_W-1:0] lock_index,
	input  logic [lmrr_pkg::ID_W-1:0]   client_id,
	output lmrr_pkg::tbl_rd_t           tbl_rd,
	output lmrr_pkg::tbl_wr_t           tbl_wr,
	input  lmrr_pkg::entry_t            tbl_data,
	input  logic                       out_free,
	output logic                       out_push,
	output lmrr_pkg::msg_t              out_msg
);
	import lmrr_pkg::*;

	ctrl_state_t            state_q, state_d;
	logic                   op_q;
	logic [LOCK_W-1:0]      lock_q;
	logic [CLIENT_W-1:0]    client_q;
	logic [CLIENT_W-1:0]    owner_q, owner_d;
	logic [NUM_CLIENTS-1:0] map_q, map_d;
	logic [NUM_CLIENTS-1:0] client_bit;
	logic [NUM_CLIENTS-1:0] low_bit;
	logic [CLIENT_W-1:0]    low_idx;
	logic [NUM_CLIENTS-1:0] map_rest;

	assign client_bit = {{(NUM_CLIENTS-1){1'b0}}, 1'b1} << client_q;

	// isolate the lowest pending waiter and encode its index
	always_comb begin
		low_bit  = map_q & (~map_q + {{(NUM_CLIENTS-1){1'b0}}, 1'b1});
		map_rest = map_q & ~low_bit;
		low_idx  = '0;
		for (int i = 0; i < NUM_CLIENTS; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | CLIENT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q     <= req_type;
			lock_q   <= lock_index;
			client_q <= client_id[CLIENT_W-1:0];
		end
		owner_q <= owner_d;
		map_q   <= map_d;
	end

	always_comb begin
		state_d     = state_q;
		owner_d     = owner_q;
		map_d       = map_q;
		req_ready   = 1'b0;
		tbl_rd.en   = 1'b0;
		tbl_rd.addr = lock_index[SLOT_W-1:0];
		tbl_wr.en   = 1'b0;
		tbl_wr.addr = lock_q[SLOT_W-1:0];
		tbl_wr.data = '0;
		out_push    = 1'b0;
		out_msg.kind   = KIND_GRANT;
		out_msg.target = ID_W'(client_q);
		out_msg.lock   = lock_q;
		out_msg.last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				tbl_rd.en = req_valid;
				if (req_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (out_free) begin
					out_push = 1'b1;
					state_d  = ST_IDLE;
					if (!op_q) begin
						tbl_wr.en = 1'b1;
						if (!tbl_data.held) begin
							tbl_wr.data.held  = 1'b1;
							tbl_wr.data.owner = client_q;
							out_msg.kind      = KIND_GRANT;
						end else begin
							tbl_wr.data.held    = 1'b1;
							tbl_wr.data.owner   = tbl_data.owner;
							tbl_wr.data.waiters = tbl_data.waiters | client_bit;
							out_msg.kind        = KIND_RETRY_REPLY;
							if (tbl_data.waiters == '0) begin
								out_msg.last = 1'b0;
								owner_d      = tbl_data.owner;
								state_d      = ST_REVOKE;
							end
						end
					end else if (!tbl_data.held || tbl_data.owner != client_q) begin
						out_msg.kind = KIND_ERROR;
					end else begin
						// free the lock, then walk the former waiters
						tbl_wr.en    = 1'b1;
						out_msg.kind = KIND_ACK;
						map_d        = tbl_data.waiters;
						if (tbl_data.waiters != '0) begin
							out_msg.last = 1'b0;
							state_d      = ST_WALK;
						end
					end
				end
			end
			ST_REVOKE: begin
				out_msg.kind   = KIND_REVOKE;
				out_msg.target = ID_W'(owner_q);
				if (out_free) begin
					out_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_WALK: begin
				out_msg.kind   = KIND_RETRY_WAITER;
				out_msg.target = ID_W'(low_idx);
				out_msg.last   = (map_rest == '0);
				if (out_free) begin
					out_push = 1'b1;
					map_d    = map_rest;
					if (map_rest == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### design/lmrr_out.sv
// Output register for result beats; holds a beat while the receiver stalls.
module lmrr_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lmrr_pkg::msg_t        msg,
	output logic                 free,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,  // target_client[3:0], out_lock[11:4]
	output logic [2:0]           m_tuser,  // msg_kind[2:0]
	output logic                 m_tlast
);
	import lmrr_pkg::*;

	logic valid_q;
	msg_t msg_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (free && push) begin
			msg_q <= msg;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'b0, msg_q.lock, msg_q.target};
	assign m_tuser  = msg_q.kind;
	assign m_tlast  = msg_q.last;

endmodule

### design/lock_manager_revoke_retry.sv
// Lock table server: grants, retry replies, revokes, release acks and waiter retries.
// Requests enter on the s_ side: s_tuser is the operation (0 acquire, 1 release),
// s_tdata holds the lock index and client id. Each request produces a run of
// result beats on the m_ side, the final beat of the run marked by m_tlast;
// m_tuser carries the message kind, m_tdata the target client and the lock.
// An acquire yields one or two beats (grant, or retry reply plus revoke when it
// is the first waiter); a release yields an error, or an ack followed by one
// retry per former waiter in ascending client order.
// Sequence: the lock entry is read from the table memory on the accept edge; the
// sequencer then places the first result in the output register once that register
// is free, and each further result of the run after it in turn. Only one request
// is in flight at a time; the table read and the one-beat output register lie
// between each request and its results.
// Reset clears the valid bit of every table entry at once, so all locks are free
// and without waiters immediately; no sweep follows.
// When the receiver stalls, the pending beat holds in the output register and
// the sequencer waits; s_tready stays low until the run's last beat is registered.
module lock_manager_revoke_retry (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // lock_index[7:0], client_id[11:8]
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // target_client[3:0], out_lock[11:4]
	output logic [2:0]  m_tuser,   // msg_kind[2:0]
	output logic        m_tlast
);
	import lmrr_pkg::*;

	tbl_rd_t tbl_rd;
	tbl_wr_t tbl_wr;
	entry_t  tbl_data;
	logic    out_free;
	logic    out_push;
	msg_t    out_msg;

	lmrr_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (tbl_rd),
		.wr      (tbl_wr),
		.rd_data (tbl_data)
	);

	lmrr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.req_type   (s_tuser),
		.lock_index (s_tdata[7:0]),
		.client_id  (s_tdata[11:8]),
		.tbl_rd     (tbl_rd),
		.tbl_wr     (tbl_wr),
		.tbl_data   (tbl_data),
		.out_free   (out_free),
		.out_push   (out_push),
		.out_msg    (out_msg)
	);

	lmrr_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (out_push),
		.msg      (out_msg),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### design/lmrr_checker.sv
// Port-level checks for the lock manager, bound to the top level.
module lmrr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);
	import lmrr_pkg::*;

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("stalled result beat changed");

	// one request at a time: drop ready after an accepted beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one in flight");

	// single-beat and closing kinds always end the run
	a_last_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_GRANT || m_tuser == KIND_ERROR ||
			m_tuser == KIND_REVOKE) |-> m_tlast)
		else $error("grant, error or revoke without tlast");

	// results appear only while a request is being worked
	a_no_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result beat without an active request");

endmodule

bind lock_manager_revoke_retry lmrr_checker u_lmrr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
